// ----- sv/rc4sc_pkg.sv -----
package rc4sc_pkg;

    // Input item: key byte or data byte
    typedef struct packed {
        logic       func;
        logic [7:0] byte_in;
        logic       last;
    } t_in_item;

    // Result item: one per data byte
    typedef struct packed {
        logic [7:0] byte_out;
        logic       last_out;
    } t_out_item;

    // Item kinds carried in func
    localparam logic FUNC_KEY  = 1'b0;
    localparam logic FUNC_DATA = 1'b1;

endpackage

// ----- sv/rc4_stream_cipher_top.sv -----
// RC4 byte cipher. Key bytes (func = 0) are stored in order. The key byte
// marked last starts the key schedule: a pass that loads the identity
// permutation, then 256 mixing steps, during which no item is taken. Each
// data byte (func = 1) passes through the single read/write permutation
// memory (read S[i], read S[j], two writes for the swap, read S[t]). It
// gives one result: the input XOR the keystream byte, or the input
// unchanged when the two are equal. The data byte marked last reruns the
// key schedule so the next message starts fresh. After reset the block
// first clears the key store and schedules a one-byte zero key. Key bytes
// beyond MAX_KEY_BYTES are dropped; a last mark still ends the key.
module rc4_stream_cipher_top #(
    parameter int MAX_KEY_BYTES = 256
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_in_valid,
    output logic                 o_in_stall,
    input  rc4sc_pkg::t_in_item  i_in_data,
    output logic                 o_out_valid,
    input  logic                 i_out_stall,
    output rc4sc_pkg::t_out_item o_out_data
);
    import rc4sc_pkg::*;

    localparam logic [8:0] KeyMax = 9'(MAX_KEY_BYTES);

    // Sequencer codes
    localparam logic [3:0] ST_IDLE = 4'd0;
    localparam logic [3:0] ST_INIT = 4'd1;
    localparam logic [3:0] ST_S_RD = 4'd2;
    localparam logic [3:0] ST_S_J  = 4'd3;
    localparam logic [3:0] ST_S_W1 = 4'd4;
    localparam logic [3:0] ST_S_W2 = 4'd5;
    localparam logic [3:0] ST_D_J  = 4'd6;
    localparam logic [3:0] ST_D_W1 = 4'd7;
    localparam logic [3:0] ST_D_W2 = 4'd8;
    localparam logic [3:0] ST_D_OUT = 4'd9;

    // Permutation and key memories
    logic [7:0] perm_mem [256];
    logic [7:0] key_mem  [256];

    logic [3:0] r_state, n_state;
    logic [7:0] r_n, n_n;
    logic [7:0] r_i, n_i;
    logic [7:0] r_j, n_j;
    logic [7:0] r_si, n_si;
    logic [7:0] r_sj, n_sj;
    logic [7:0] r_t, n_t;
    logic [8:0] r_kidx, n_kidx;
    logic [8:0] r_key_count, n_key_count;
    logic [8:0] r_key_len, n_key_len;
    logic       r_clr_key, n_clr_key;
    logic [7:0] r_byte, n_byte;
    logic       r_last, n_last;
    logic       r_out_valid, n_out_valid;
    t_out_item  r_out, n_out;

    logic [7:0] r_perm_rd;
    logic [7:0] r_key_rd;
    logic [7:0] perm_raddr, perm_waddr, perm_wdata;
    logic       perm_we;
    logic [7:0] key_raddr, key_waddr, key_wdata;
    logic       key_we;

    logic       in_acc;
    logic       out_free;
    logic [7:0] j_sched, j_data, t_sum, ks;
    logic [8:0] kidx_inc;

    assign in_acc   = i_in_valid && (r_state == ST_IDLE);
    assign out_free = !r_out_valid || !i_out_stall;
    assign j_sched  = r_j + r_perm_rd + r_key_rd;
    assign j_data   = r_j + r_perm_rd;
    assign t_sum    = r_si + r_sj;
    assign kidx_inc = r_kidx + 9'd1;
    // Latest write to S[j] is not yet seen by the read of S[t]
    assign ks       = (r_t == r_j) ? r_si : r_perm_rd;

    // Memories: one write and one registered read each cycle
    always_ff @(posedge i_clk) begin
        if (perm_we) begin
            perm_mem[perm_waddr] <= perm_wdata;
        end
        r_perm_rd <= perm_mem[perm_raddr];
        if (key_we) begin
            key_mem[key_waddr] <= key_wdata;
        end
        r_key_rd <= key_mem[key_raddr];
    end

    // Sequencer and datapath
    always_comb begin
        n_state     = r_state;
        n_n         = r_n;
        n_i         = r_i;
        n_j         = r_j;
        n_si        = r_si;
        n_sj        = r_sj;
        n_t         = r_t;
        n_kidx      = r_kidx;
        n_key_count = r_key_count;
        n_key_len   = r_key_len;
        n_clr_key   = r_clr_key;
        n_byte      = r_byte;
        n_last      = r_last;
        n_out_valid = r_out_valid && i_out_stall;
        n_out       = r_out;
        perm_raddr  = r_n;
        perm_we     = 1'b0;
        perm_waddr  = r_n;
        perm_wdata  = r_n;
        key_raddr   = r_kidx[7:0];
        key_we      = 1'b0;
        key_waddr   = r_key_count[7:0];
        key_wdata   = i_in_data.byte_in;

        unique case (r_state)
            ST_IDLE: begin
                perm_raddr = r_i + 8'd1;
                if (in_acc) begin
                    if (i_in_data.func == FUNC_DATA) begin
                        n_i     = r_i + 8'd1;
                        n_byte  = i_in_data.byte_in;
                        n_last  = i_in_data.last;
                        n_state = ST_D_J;
                    end else begin
                        // Store key byte, drop it past the limit
                        if (r_key_count < KeyMax) begin
                            key_we      = 1'b1;
                            n_key_count = r_key_count + 9'd1;
                        end
                        if (i_in_data.last) begin
                            n_key_len   = (r_key_count < KeyMax) ?
                                          r_key_count + 9'd1 : r_key_count;
                            n_key_count = 9'd0;
                            n_n         = 8'd0;
                            n_clr_key   = 1'b0;
                            n_state     = ST_INIT;
                        end
                    end
                end
            end
            ST_INIT: begin
                // Load identity permutation, clear the key store after reset
                perm_we   = 1'b1;
                key_we    = r_clr_key;
                key_waddr = r_n;
                key_wdata = 8'd0;
                n_n       = r_n + 8'd1;
                if (r_n == 8'hFF) begin
                    n_j     = 8'd0;
                    n_kidx  = 9'd0;
                    n_state = ST_S_RD;
                end
            end
            ST_S_RD: begin
                n_state = ST_S_J;
            end
            ST_S_J: begin
                n_si       = r_perm_rd;
                n_j        = j_sched;
                perm_raddr = j_sched;
                n_state    = ST_S_W1;
            end
            ST_S_W1: begin
                perm_we    = 1'b1;
                perm_wdata = r_perm_rd;
                n_state    = ST_S_W2;
            end
            ST_S_W2: begin
                perm_we    = 1'b1;
                perm_waddr = r_j;
                perm_wdata = r_si;
                n_n        = r_n + 8'd1;
                n_kidx     = (kidx_inc >= r_key_len) ? 9'd0 : kidx_inc;
                if (r_n == 8'hFF) begin
                    n_i     = 8'd0;
                    n_j     = 8'd0;
                    n_state = ST_IDLE;
                end else begin
                    n_state = ST_S_RD;
                end
            end
            ST_D_J: begin
                n_si       = r_perm_rd;
                n_j        = j_data;
                perm_raddr = j_data;
                n_state    = ST_D_W1;
            end
            ST_D_W1: begin
                n_sj       = r_perm_rd;
                perm_we    = 1'b1;
                perm_waddr = r_i;
                perm_wdata = r_perm_rd;
                n_state    = ST_D_W2;
            end
            ST_D_W2: begin
                perm_we    = 1'b1;
                perm_waddr = r_j;
                perm_wdata = r_si;
                perm_raddr = t_sum;
                n_t        = t_sum;
                n_state    = ST_D_OUT;
            end
            ST_D_OUT: begin
                // Hold the read of S[t] until the result register frees up
                perm_raddr = r_t;
                if (out_free) begin
                    n_out_valid    = 1'b1;
                    n_out.byte_out = (ks == r_byte) ? r_byte : (r_byte ^ ks);
                    n_out.last_out = r_last;
                    if (r_last) begin
                        n_n       = 8'd0;
                        n_clr_key = 1'b0;
                        n_state   = ST_INIT;
                    end else begin
                        n_state = ST_IDLE;
                    end
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    // Control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_INIT;
            r_n         <= 8'd0;
            r_i         <= 8'd0;
            r_j         <= 8'd0;
            r_kidx      <= 9'd0;
            r_key_count <= 9'd0;
            r_key_len   <= 9'd1;
            r_clr_key   <= 1'b1;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_n         <= n_n;
            r_i         <= n_i;
            r_j         <= n_j;
            r_kidx      <= n_kidx;
            r_key_count <= n_key_count;
            r_key_len   <= n_key_len;
            r_clr_key   <= n_clr_key;
            r_out_valid <= n_out_valid;
        end
    end

    // Payload registers
    always_ff @(posedge i_clk) begin
        r_si   <= n_si;
        r_sj   <= n_sj;
        r_t    <= n_t;
        r_byte <= n_byte;
        r_last <= n_last;
        r_out  <= n_out;
    end

    assign o_in_stall  = (r_state != ST_IDLE);
    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out;

endmodule

// ----- verif/rc4_stream_cipher_top_test.sv -----
module rc4_stream_cipher_top_test;
    timeunit 1ns;
    timeprecision 1ps;

    import rc4sc_pkg::*;

    localparam int CLK_PERIOD    = 12;
    localparam int KEY_BYTES_MAX = 256;
    localparam int CYCLE_LIMIT   = 1_200_000;
    // One full key schedule plus margin
    localparam int TAIL_CYCLES   = 1400;
    // Outlasts a key schedule still running, so the block backs up behind the held result
    localparam int HOLDOFF_LEN   = 2400;

    logic      i_clk       = 1'b0;
    logic      i_rst_n     = 1'b0;
    logic      i_in_valid  = 1'b0;
    logic      o_in_stall;
    t_in_item  i_in_data   = '0;
    logic      o_out_valid;
    logic      i_out_stall = 1'b0;
    t_out_item o_out_data;

    // Cipher state mirrored from the block
    logic [7:0]  perm    [256];
    logic [7:0]  key_mem [256];
    int unsigned key_cnt;
    int unsigned key_len;
    logic [7:0]  idx_i;
    logic [7:0]  idx_j;
    t_out_item   expected_q[$];

    int unsigned in_idle_pct   = 0;
    int unsigned out_stall_pct = 0;
    int unsigned out_hold_left = 0;
    int unsigned items_sent    = 0;
    int unsigned err_count     = 0;
    int unsigned cycle_count   = 0;

    rc4_stream_cipher_top #(
        .MAX_KEY_BYTES(KEY_BYTES_MAX)
    ) u_dut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .o_in_stall (o_in_stall),
        .i_in_data  (i_in_data),
        .o_out_valid(o_out_valid),
        .i_out_stall(i_out_stall),
        .o_out_data (o_out_data)
    );

    always #(CLK_PERIOD / 2) i_clk = ~i_clk;

    // Rebuild the permutation from the stored key and clear the indices
    function automatic void rc4_rekey();
        int unsigned n;
        int unsigned len;
        logic [7:0]  j;
        logic [7:0]  sw;
        len = key_len;
        if (len == 0 || len > KEY_BYTES_MAX) begin
            len = 1;
        end
        for (n = 0; n < 256; n++) begin
            perm[n] = n[7:0];
        end
        j = 8'd0;
        for (n = 0; n < 256; n++) begin
            j = j + perm[n] + key_mem[n % len];
            sw = perm[n];
            perm[n] = perm[j];
            perm[j] = sw;
        end
        idx_i = 8'd0;
        idx_j = 8'd0;
    endfunction

    // Keystream byte the next data item will use, state left untouched
    function automatic logic [7:0] next_keystream();
        logic [7:0] ii;
        logic [7:0] jj;
        logic [7:0] si;
        logic [7:0] sj;
        logic [7:0] t;
        ii = idx_i + 8'd1;
        jj = idx_j + perm[ii];
        si = perm[jj];
        sj = perm[ii];
        t  = si + sj;
        if (t == ii) begin
            return si;
        end else if (t == jj) begin
            return sj;
        end
        return perm[t];
    endfunction

    // Advance the cipher state by one accepted item, queue any output byte
    function automatic void rc4_absorb(input t_in_item item);
        logic [7:0] sw;
        logic [7:0] t;
        logic [7:0] ks;
        t_out_item  res;
        if (item.func == FUNC_KEY) begin
            if (key_cnt < KEY_BYTES_MAX) begin
                key_mem[key_cnt % 256] = item.byte_in;
                key_cnt++;
            end
            if (item.last) begin
                key_len = key_cnt;
                key_cnt = 0;
                rc4_rekey();
            end
        end else begin
            idx_i = idx_i + 8'd1;
            idx_j = idx_j + perm[idx_i];
            sw = perm[idx_i];
            perm[idx_i] = perm[idx_j];
            perm[idx_j] = sw;
            t  = perm[idx_i] + perm[idx_j];
            ks = perm[t];
            res.byte_out = (ks == item.byte_in) ? item.byte_in : (item.byte_in ^ ks);
            res.last_out = item.last;
            expected_q.push_back(res);
            if (item.last) begin
                rc4_rekey();
            end
        end
    endfunction

    function automatic t_in_item make_item(input logic f, input logic [7:0] b, input logic l);
        t_in_item item;
        item.func    = f;
        item.byte_in = b;
        item.last    = l;
        return item;
    endfunction

    // Offer one item, hold it until accepted, return at the next falling edge
    task automatic send_item(input t_in_item item);
        while ($urandom_range(99) < in_idle_pct) begin
            i_in_valid <= 1'b0;
            @(negedge i_clk);
        end
        i_in_valid <= 1'b1;
        i_in_data  <= item;
        do begin
            @(posedge i_clk);
        end while (o_in_stall !== 1'b0);
        rc4_absorb(item);
        items_sent++;
        @(negedge i_clk);
    endtask

    task automatic send_key(input int unsigned len, input logic mark_last);
        int unsigned n;
        for (n = 0; n < len; n++) begin
            send_item(make_item(FUNC_KEY, 8'($urandom), mark_last && (n == len - 1)));
        end
    endtask

    // Random message; some bytes equal their keystream byte
    task automatic send_message(input int unsigned len);
        int unsigned n;
        logic [7:0]  b;
        for (n = 0; n < len; n++) begin
            b = 8'($urandom);
            if ($urandom_range(99) < 10) begin
                b = next_keystream();
            end
            send_item(make_item(FUNC_DATA, b, n == len - 1));
        end
    endtask

    // Stop offering and wait for every pending output byte
    task automatic wait_for_results();
        i_in_valid <= 1'b0;
        while (expected_q.size() != 0) begin
            @(posedge i_clk);
        end
        @(negedge i_clk);
    endtask

    task automatic test_directed_cases();
        // Default key after reset, byte extremes and a pass-through byte
        send_item(make_item(FUNC_DATA, 8'h00, 1'b0));
        send_item(make_item(FUNC_DATA, 8'hFF, 1'b0));
        send_item(make_item(FUNC_DATA, next_keystream(), 1'b0));
        send_item(make_item(FUNC_DATA, 8'hA5, 1'b1));
        // One-byte all-ones key
        send_item(make_item(FUNC_KEY, 8'hFF, 1'b1));
        send_item(make_item(FUNC_DATA, 8'h00, 1'b0));
        send_item(make_item(FUNC_DATA, next_keystream(), 1'b1));
        // Key of zero bytes, single-byte message
        send_item(make_item(FUNC_KEY, 8'h00, 1'b0));
        send_item(make_item(FUNC_KEY, 8'h00, 1'b1));
        send_item(make_item(FUNC_DATA, 8'hFF, 1'b1));
        // Data in the middle of a key load, then finish the key
        send_item(make_item(FUNC_KEY, 8'h80, 1'b0));
        send_item(make_item(FUNC_KEY, 8'h01, 1'b0));
        send_item(make_item(FUNC_DATA, 8'h7F, 1'b0));
        send_item(make_item(FUNC_DATA, next_keystream(), 1'b1));
        send_item(make_item(FUNC_KEY, 8'h5A, 1'b1));
        send_item(make_item(FUNC_DATA, 8'h55, 1'b0));
        send_item(make_item(FUNC_DATA, 8'hAA, 1'b0));
        send_item(make_item(FUNC_DATA, 8'h01, 1'b1));
        wait_for_results();
    endtask

    // Key longer than the store: extra bytes dropped, last still ends it
    task automatic test_long_key();
        send_key(KEY_BYTES_MAX + 4, 1'b1);
        send_message(6);
        wait_for_results();
    endtask

    task automatic test_random_traffic(input int unsigned n_items, input int unsigned in_pct,
                                       input int unsigned out_pct);
        int unsigned start;
        int unsigned pick;
        in_idle_pct   = in_pct;
        out_stall_pct = out_pct;
        start = items_sent;
        while (items_sent - start < n_items) begin
            pick = $urandom_range(99);
            if (pick < 15) begin
                send_key(($urandom_range(99) < 90) ? $urandom_range(1, 16)
                                                    : $urandom_range(17, 64), 1'b1);
            end else if (pick < 80) begin
                send_message($urandom_range(1, 24));
            end else if (pick < 90) begin
                // Broken key load: message arrives before the key is finished
                send_key($urandom_range(1, 4), 1'b0);
                send_message($urandom_range(1, 8));
            end else begin
                send_item(make_item(1'($urandom), 8'($urandom), 1'($urandom)));
            end
        end
        wait_for_results();
    endtask

    // Receiver holds off while items keep coming, so the input backs up
    task automatic test_output_holdoff();
        in_idle_pct   = 0;
        out_stall_pct = 0;
        @(posedge i_clk);
        out_hold_left = HOLDOFF_LEN;
        @(negedge i_clk);
        send_message(12);
        send_message(10);
        wait_for_results();
    endtask

    // Receiver stall, with an occasional long hold-off
    always @(negedge i_clk) begin
        if (out_hold_left > 0) begin
            i_out_stall <= 1'b1;
            out_hold_left--;
        end else begin
            i_out_stall <= ($urandom_range(99) < out_stall_pct);
        end
    end

    // Compare each accepted output byte with the oldest prediction
    always @(posedge i_clk) begin : check_results
        t_out_item want;
        if (i_rst_n && o_out_valid === 1'b1 && i_out_stall === 1'b0) begin
            if (expected_q.size() == 0) begin
                $display("%0t: unexpected item byte_out=%02h last_out=%b",
                         $time, o_out_data.byte_out, o_out_data.last_out);
                err_count++;
            end else begin
                want = expected_q.pop_front();
                if (o_out_data.byte_out !== want.byte_out) begin
                    $display("%0t: byte_out expected %02h actual %02h",
                             $time, want.byte_out, o_out_data.byte_out);
                    err_count++;
                end
                if (o_out_data.last_out !== want.last_out) begin
                    $display("%0t: last_out expected %b actual %b",
                             $time, want.last_out, o_out_data.last_out);
                    err_count++;
                end
            end
        end
    end

    // Abort a hung run
    always @(posedge i_clk) begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("[rc4_stream_cipher_top] ERROR");
            $finish;
        end
    end

    initial begin
        int unsigned n;
        for (n = 0; n < 256; n++) begin
            key_mem[n] = 8'd0;
        end
        key_cnt = 0;
        key_len = 1;
        rc4_rekey();

        repeat (6) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        test_directed_cases();
        test_long_key();
        test_random_traffic(270, 0, 0);
        test_random_traffic(270, 68, 0);
        test_random_traffic(270, 0, 68);
        test_random_traffic(270, 13, 13);
        test_output_holdoff();

        // Drain, then watch for stray output bytes
        out_stall_pct = 0;
        wait_for_results();
        repeat (TAIL_CYCLES) @(posedge i_clk);
        if (expected_q.size() != 0) begin
            $display("%0t: %0d output bytes never arrived", $time, expected_q.size());
            err_count++;
        end
        if (err_count == 0) begin
            $display("[rc4_stream_cipher_top] OK");
        end else begin
            $display("[rc4_stream_cipher_top] ERROR");
        end
        $finish;
    end

endmodule

// ----- rc4_stream_cipher_top.f -----
sv/rc4sc_pkg.sv
sv/rc4_stream_cipher_top.sv
verif/rc4_stream_cipher_top_test.sv
